>>> hdl/tqaa_pkg.sv
// Package for the two-queue admission arbiter.
// Holds request, admission, served and policy codes, register indexes,
// reset values and the payload and control structs. No dependencies.
`default_nettype none

package tqaa_pkg;

   // Request codes carried in req_type
   typedef enum logic [1:0] {
      REQ_ARRIVE_ONE   = 2'd0,
      REQ_ARRIVE_TWO   = 2'd1,
      REQ_SERVICE_DONE = 2'd2,
      REQ_IGNORED      = 2'd3
   } req_code_type;

   // Admission outcome codes
   typedef enum logic [1:0] {
      ADM_SERVED_NOW = 2'd0,
      ADM_QUEUED     = 2'd1,
      ADM_REJECTED   = 2'd2,
      ADM_NONE       = 2'd3
   } adm_code_type;

   // Queue taken on service done
   typedef enum logic [1:0] {
      SERVED_NONE = 2'd0,
      SERVED_ONE  = 2'd1,
      SERVED_TWO  = 2'd2
   } served_code_type;

   // Arbitration policies; the unused code falls back to longest
   typedef enum logic [2:0] {
      POL_LONGEST  = 3'd0,
      POL_RANDOM   = 3'd1,
      POL_SHORTEST = 3'd2,
      POL_ALTERNATE = 3'd3,
      POL_BURST    = 3'd4,
      POL_FULLEST  = 3'd5,
      POL_WEIGHTED = 3'd6
   } policy_code_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_POLICY       = 3'd0,
      CSR_CAPACITY_ONE = 3'd1,
      CSR_CAPACITY_TWO = 3'd2,
      CSR_WEIGHT       = 3'd3,
      CSR_BURST_ONE    = 3'd4,
      CSR_BURST_TWO    = 3'd5
   } csr_index_type;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   // Reset values of the configuration registers
   localparam logic [7:0]  CAPACITY_RESET = 8'd16;
   localparam logic [15:0] WEIGHT_RESET   = 16'd32768;
   localparam logic [7:0]  BURST_RESET    = 8'd5;

   typedef struct packed {
      logic [2:0]  policy;
      logic [7:0]  capacity_one;
      logic [7:0]  capacity_two;
      logic [15:0] weight_threshold;
      logic [7:0]  burst_len_one;
      logic [7:0]  burst_len_two;
   } cfg_type;

   typedef struct packed {
      logic [7:0] count_one;
      logic [7:0] count_two;
   } burst_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] random_sample;
   } req_data_type;

   typedef struct packed {
      logic [1:0]  served_queue;
      logic [1:0]  admission;
      logic [7:0]  length_one;
      logic [7:0]  length_two;
      logic        server_busy_out;
      logic [31:0] arrivals_one;
      logic [31:0] arrivals_two;
      logic [31:0] rejects_one;
      logic [31:0] rejects_two;
   } rsp_data_type;

endpackage

`default_nettype wire

>>> hdl/tqaa_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on tqaa_pkg for the payload structs.
`default_nettype none

interface tqaa_req_if;
   logic                   valid;
   logic                   ready;
   tqaa_pkg::req_data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface tqaa_rsp_if;
   logic                   valid;
   logic                   ready;
   tqaa_pkg::rsp_data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/tqaa_pick.sv
// Policy decision for a service done with both queues holding items.
// Returns the chosen queue and the next burst counters. Depends on tqaa_pkg.
`default_nettype none

module tqaa_pick #(
   parameter int unsigned LEN_WIDTH = 8
) (
   input  tqaa_pkg::cfg_type        cfg,
   input  logic [LEN_WIDTH-1:0]     len_one,
   input  logic [LEN_WIDTH-1:0]     len_two,
   input  logic [1:0]               last_choice,
   input  tqaa_pkg::burst_type      burst_cur,
   input  logic [15:0]              sample,
   output logic [1:0]               pick,
   output tqaa_pkg::burst_type      burst_next
);

   localparam int unsigned PROD_WIDTH = LEN_WIDTH + 8;

   logic [1:0]            tie;
   logic [PROD_WIDTH-1:0] fill_one;
   logic [PROD_WIDTH-1:0] fill_two;
   logic [7:0]            blen_one;
   logic [7:0]            blen_two;
   logic [7:0]            bcnt_one;
   logic [1:0]            burst_pick;
   tqaa_pkg::burst_type   burst_upd;

   // Tie break: lower half of the sample takes queue one
   assign tie = sample[15] ? tqaa_pkg::SERVED_TWO : tqaa_pkg::SERVED_ONE;

   // Fullness by capacity ratio, cross multiplied
   assign fill_one = PROD_WIDTH'(len_one) * PROD_WIDTH'(cfg.capacity_two);
   assign fill_two = PROD_WIDTH'(len_two) * PROD_WIDTH'(cfg.capacity_one);

   // Burst step: a zero length acts as one
   always_comb begin
      blen_one  = (cfg.burst_len_one == 8'd0) ? 8'd1 : cfg.burst_len_one;
      blen_two  = (cfg.burst_len_two == 8'd0) ? 8'd1 : cfg.burst_len_two;
      burst_upd = burst_cur;
      bcnt_one  = burst_cur.count_one;
      if (burst_cur.count_one >= blen_one && burst_cur.count_two >= blen_two) begin
         bcnt_one = 8'd0;
      end
      burst_upd.count_one = bcnt_one;
      if (bcnt_one < blen_one) begin
         burst_pick          = tqaa_pkg::SERVED_ONE;
         burst_upd.count_one = bcnt_one + 8'd1;
         if (burst_upd.count_one >= blen_one) begin
            burst_upd.count_two = 8'd0;
         end
      end else begin
         burst_pick          = tqaa_pkg::SERVED_TWO;
         burst_upd.count_two = burst_cur.count_two + 8'd1;
         if (burst_upd.count_two >= blen_two) begin
            burst_upd.count_one = 8'd0;
         end
      end
   end

   // Select by policy
   always_comb begin
      burst_next = burst_cur;
      case (cfg.policy)
         tqaa_pkg::POL_RANDOM: begin
            pick = tie;
         end
         tqaa_pkg::POL_SHORTEST: begin
            if (len_one < len_two) pick = tqaa_pkg::SERVED_ONE;
            else if (len_two < len_one) pick = tqaa_pkg::SERVED_TWO;
            else pick = tie;
         end
         tqaa_pkg::POL_ALTERNATE: begin
            pick = (last_choice == tqaa_pkg::SERVED_ONE) ? tqaa_pkg::SERVED_TWO
                                                         : tqaa_pkg::SERVED_ONE;
         end
         tqaa_pkg::POL_BURST: begin
            pick       = burst_pick;
            burst_next = burst_upd;
         end
         tqaa_pkg::POL_FULLEST: begin
            if (fill_one > fill_two) pick = tqaa_pkg::SERVED_ONE;
            else if (fill_two > fill_one) pick = tqaa_pkg::SERVED_TWO;
            else pick = tie;
         end
         tqaa_pkg::POL_WEIGHTED: begin
            pick = (sample < cfg.weight_threshold) ? tqaa_pkg::SERVED_ONE
                                                    : tqaa_pkg::SERVED_TWO;
         end
         default: begin
            if (len_one > len_two) pick = tqaa_pkg::SERVED_ONE;
            else if (len_two > len_one) pick = tqaa_pkg::SERVED_TWO;
            else pick = tie;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hdl/two_queue_admission_arbiter.sv
// Two-queue admission arbiter top level: input register, event logic,
// state and result register. Depends on tqaa_pkg, tqaa_if and tqaa_pick.
//
//   channel  direction  handshake         payload
//   req      in         valid/ready       req_type, random_sample
//   rsp      out        valid/ready       served_queue .. rejects_two
//   csr      in         csr_write only    csr_index, csr_wdata
//
// One transaction per cycle sustained while rsp is ready; each transaction
// passes from acceptance to response through the input register, the single
// pass of event logic and the result register. Synchronous reset clears state and
// configuration to defaults. A stalled response holds the input register,
// and req.ready drops only when both registers are full and rsp is stalled.
`default_nettype none

module two_queue_admission_arbiter #(
   parameter int unsigned QUEUE_LIMIT = 255,
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   tqaa_req_if.sink                                  req,
   tqaa_rsp_if.source                                rsp,
   input  wire logic                                 csr_write,
   input  wire logic [tqaa_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [tqaa_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int unsigned LEN_WIDTH = $clog2(QUEUE_LIMIT);
   localparam int unsigned SUM_WIDTH = LEN_WIDTH + 9;
   localparam logic [SUM_WIDTH-1:0] LIMIT = SUM_WIDTH'(QUEUE_LIMIT);

   // Configuration
   tqaa_pkg::cfg_type cfg_ff;

   // Input register
   logic                   in_valid_ff;
   tqaa_pkg::req_data_type in_data_ff;

   // Arbiter state
   logic [LEN_WIDTH-1:0]   len_one_ff, len_one_in;
   logic [LEN_WIDTH-1:0]   len_two_ff, len_two_in;
   logic                   busy_ff, busy_in;
   logic [1:0]             last_ff, last_in;
   tqaa_pkg::burst_type    burst_ff, burst_in;
   logic [COUNT_WIDTH-1:0] arr_one_ff, arr_one_in;
   logic [COUNT_WIDTH-1:0] arr_two_ff, arr_two_in;
   logic [COUNT_WIDTH-1:0] rej_one_ff, rej_one_in;
   logic [COUNT_WIDTH-1:0] rej_two_ff, rej_two_in;

   // Result register
   logic                   out_valid_ff;
   tqaa_pkg::rsp_data_type out_data_ff, out_data_in;

   logic                   advance;
   logic [1:0]             pick;
   tqaa_pkg::burst_type    burst_pick;
   logic [1:0]             served;
   logic [1:0]             adm;
   logic [SUM_WIDTH-1:0]   grown;
   logic [SUM_WIDTH-1:0]   cap_sel;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_data_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.policy           <= tqaa_pkg::POL_LONGEST;
         cfg_ff.capacity_one     <= tqaa_pkg::CAPACITY_RESET;
         cfg_ff.capacity_two     <= tqaa_pkg::CAPACITY_RESET;
         cfg_ff.weight_threshold <= tqaa_pkg::WEIGHT_RESET;
         cfg_ff.burst_len_one    <= tqaa_pkg::BURST_RESET;
         cfg_ff.burst_len_two    <= tqaa_pkg::BURST_RESET;
      end else if (csr_write) begin
         case (csr_index)
            tqaa_pkg::CSR_POLICY:       cfg_ff.policy           <= csr_wdata[2:0];
            tqaa_pkg::CSR_CAPACITY_ONE: cfg_ff.capacity_one     <= csr_wdata[7:0];
            tqaa_pkg::CSR_CAPACITY_TWO: cfg_ff.capacity_two     <= csr_wdata[7:0];
            tqaa_pkg::CSR_WEIGHT:       cfg_ff.weight_threshold <= csr_wdata;
            tqaa_pkg::CSR_BURST_ONE:    cfg_ff.burst_len_one    <= csr_wdata[7:0];
            tqaa_pkg::CSR_BURST_TWO:    cfg_ff.burst_len_two    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Capture a request transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_data_ff <= req.data;
      end
   end

   // Policy decision for the two-queue case
   tqaa_pick #(
      .LEN_WIDTH (LEN_WIDTH)
   ) u_pick (
      .cfg         (cfg_ff),
      .len_one     (len_one_ff),
      .len_two     (len_two_ff),
      .last_choice (last_ff),
      .burst_cur   (burst_ff),
      .sample      (in_data_ff.random_sample),
      .pick        (pick),
      .burst_next  (burst_pick)
   );

   // Event logic: admit, queue or reject an arrival; hand over on service done
   always_comb begin
      len_one_in = len_one_ff;
      len_two_in = len_two_ff;
      busy_in    = busy_ff;
      last_in    = last_ff;
      burst_in   = burst_ff;
      arr_one_in = arr_one_ff;
      arr_two_in = arr_two_ff;
      rej_one_in = rej_one_ff;
      rej_two_in = rej_two_ff;
      served     = tqaa_pkg::SERVED_NONE;
      adm        = tqaa_pkg::ADM_NONE;
      if (in_data_ff.req_type == tqaa_pkg::REQ_ARRIVE_ONE) begin
         grown   = SUM_WIDTH'(len_one_ff) + SUM_WIDTH'(1);
         cap_sel = SUM_WIDTH'(cfg_ff.capacity_one);
      end else begin
         grown   = SUM_WIDTH'(len_two_ff) + SUM_WIDTH'(1);
         cap_sel = SUM_WIDTH'(cfg_ff.capacity_two);
      end
      case (in_data_ff.req_type)
         tqaa_pkg::REQ_ARRIVE_ONE, tqaa_pkg::REQ_ARRIVE_TWO: begin
            if (in_data_ff.req_type == tqaa_pkg::REQ_ARRIVE_ONE) begin
               arr_one_in = (arr_one_ff == '1) ? arr_one_ff : arr_one_ff + 1'b1;
            end else begin
               arr_two_in = (arr_two_ff == '1) ? arr_two_ff : arr_two_ff + 1'b1;
            end
            if (!busy_ff) begin
               busy_in = 1'b1;
               adm     = tqaa_pkg::ADM_SERVED_NOW;
            end else if (grown < cap_sel && grown < LIMIT) begin
               adm = tqaa_pkg::ADM_QUEUED;
               if (in_data_ff.req_type == tqaa_pkg::REQ_ARRIVE_ONE) begin
                  len_one_in = grown[LEN_WIDTH-1:0];
               end else begin
                  len_two_in = grown[LEN_WIDTH-1:0];
               end
            end else begin
               adm = tqaa_pkg::ADM_REJECTED;
               if (in_data_ff.req_type == tqaa_pkg::REQ_ARRIVE_ONE) begin
                  rej_one_in = (rej_one_ff == '1) ? rej_one_ff : rej_one_ff + 1'b1;
               end else begin
                  rej_two_in = (rej_two_ff == '1) ? rej_two_ff : rej_two_ff + 1'b1;
               end
            end
         end
         tqaa_pkg::REQ_SERVICE_DONE: begin
            if (len_one_ff == '0 && len_two_ff == '0) begin
               served = tqaa_pkg::SERVED_NONE;
            end else if (len_one_ff == '0) begin
               served = tqaa_pkg::SERVED_TWO;
            end else if (len_two_ff == '0) begin
               served = tqaa_pkg::SERVED_ONE;
            end else begin
               served   = pick;
               burst_in = burst_pick;
            end
            busy_in = (served != tqaa_pkg::SERVED_NONE);
            if (served == tqaa_pkg::SERVED_ONE) len_one_in = len_one_ff - 1'b1;
            if (served == tqaa_pkg::SERVED_TWO) len_two_in = len_two_ff - 1'b1;
            last_in = served;
         end
         default: ;
      endcase

      out_data_in.served_queue    = served;
      out_data_in.admission       = adm;
      out_data_in.length_one      = 8'(len_one_in);
      out_data_in.length_two      = 8'(len_two_in);
      out_data_in.server_busy_out = busy_in;
      out_data_in.arrivals_one    = 32'(arr_one_in);
      out_data_in.arrivals_two    = 32'(arr_two_in);
      out_data_in.rejects_one     = 32'(rej_one_in);
      out_data_in.rejects_two     = 32'(rej_two_in);
   end

   // Advance state on each processed transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         len_one_ff <= '0;
         len_two_ff <= '0;
         busy_ff    <= 1'b0;
         last_ff    <= tqaa_pkg::SERVED_NONE;
         burst_ff   <= '0;
         arr_one_ff <= '0;
         arr_two_ff <= '0;
         rej_one_ff <= '0;
         rej_two_ff <= '0;
      end else if (advance) begin
         len_one_ff <= len_one_in;
         len_two_ff <= len_two_in;
         busy_ff    <= busy_in;
         last_ff    <= last_in;
         burst_ff   <= burst_in;
         arr_one_ff <= arr_one_in;
         arr_two_ff <= arr_two_in;
         rej_one_ff <= rej_one_in;
         rej_two_ff <= rej_two_in;
      end
   end

   // Hold the response until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   // Queue lengths stay below the bound
   assert property (@(posedge clock) disable iff (reset)
      SUM_WIDTH'(len_one_ff) < LIMIT && SUM_WIDTH'(len_two_ff) < LIMIT)
      else $error("queue length reached its bound");

   // Waiting items imply a busy server
   assert property (@(posedge clock) disable iff (reset)
      (len_one_ff != '0 || len_two_ff != '0) |-> busy_ff)
      else $error("items waiting while server free");

   // Rejections never outnumber arrivals
   assert property (@(posedge clock) disable iff (reset)
      rej_one_ff <= arr_one_ff && rej_two_ff <= arr_two_ff)
      else $error("reject count above arrival count");

   // A served queue appears only on a non-arrival response
   assert property (@(posedge clock) disable iff (reset)
      (advance && served != tqaa_pkg::SERVED_NONE) |=>
         (out_data_ff.admission == tqaa_pkg::ADM_NONE && out_data_ff.server_busy_out))
      else $error("served queue on an arrival or with server free");

endmodule

`default_nettype wire
